// ----- hw/rtl/m3i_pkg.sv -----
// Shared constants, types and helpers of the 3x3 matrix inverse pipeline.
// Used by m3i_div and matrix3x3_inverse; depends on nothing else.
package m3i_pkg;

	// Element format and fixed-point position.
	localparam int EW        = 32;
	localparam int FRAC_BITS = 16;
	localparam int NL        = 9;

	// Derived widths: products, cross products, determinant and quotient.
	localparam int PW    = 2 * EW;
	localparam int RW    = PW + 1;
	localparam int RMAGW = PW;
	localparam int DETW  = 3 * EW + 1;
	localparam int DMAGW = DETW - 1;
	localparam int NUMW  = RMAGW + 2 * FRAC_BITS + 2;
	localparam int DENW  = DMAGW + 1;
	localparam int QW    = EW + 1;
	localparam int WW    = (NUMW > DENW + QW) ? NUMW : DENW + QW;

	// Operand selection for the nine cross-product terms, r = a*b - c*d.
	localparam int unsigned XA [NL] = '{4, 7, 1, 5, 8, 2, 3, 6, 0};
	localparam int unsigned XB [NL] = '{8, 2, 5, 6, 0, 3, 7, 1, 4};
	localparam int unsigned XC [NL] = '{7, 1, 4, 8, 2, 5, 6, 0, 3};
	localparam int unsigned XD [NL] = '{5, 8, 2, 3, 6, 0, 4, 7, 1};

	// Information that travels alongside the quotient pipeline.
	typedef struct packed {
		logic          sing;
		logic [NL-1:0] qneg;
		logic [NL-1:0] ovf;
		logic [EW-1:0] det;
	} m3i_side_t;

	// Applies a sign to a magnitude and saturates to the signed element range.
	// big flags a magnitude that is at least 2^QW.
	function automatic logic [EW-1:0] m3i_sat(input logic neg, input logic big,
			input logic [QW-1:0] mag);
		logic [QW-1:0] lim_neg;
		logic [QW-1:0] lim_pos;
		logic [QW-1:0] negv;
		lim_neg = {1'b0, 1'b1, {(EW-1){1'b0}}};
		lim_pos = {2'b00, {(EW-1){1'b1}}};
		negv    = -mag;
		if (neg) begin
			if (big || (mag > lim_neg))
				return {1'b1, {(EW-1){1'b0}}};
			return negv[EW-1:0];
		end
		if (big || (mag > lim_pos))
			return {1'b0, {(EW-1){1'b1}}};
		return mag[EW-1:0];
	endfunction

endpackage

// ----- hw/rtl/m3i_div.sv -----
// Nine-lane pipelined restoring divider, one quotient bit per stage.
// Depends on m3i_pkg for widths and the sideband type.
module m3i_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [m3i_pkg::WW-1:0]    num [m3i_pkg::NL],
	input  logic [m3i_pkg::DENW-1:0]  den,
	input  m3i_pkg::m3i_side_t        side,
	output logic                      out_valid,
	output logic [m3i_pkg::QW-1:0]    quo [m3i_pkg::NL],
	output m3i_pkg::m3i_side_t        side_out
);

	genvar g, l;

	// Each stage tries to subtract the divisor shifted to its quotient bit.
	for (g = 0; g < m3i_pkg::QW; g++) begin : g_stage
		localparam int K = m3i_pkg::QW - 1 - g;
		logic                     v_in;
		logic [m3i_pkg::DENW-1:0] den_in;
		m3i_pkg::m3i_side_t       side_in;
		logic                     v_s;
		logic [m3i_pkg::DENW-1:0] den_s;
		m3i_pkg::m3i_side_t       side_s;
		logic [m3i_pkg::WW-1:0]   dsh;

		// The first stage takes the block inputs, every other stage the one before it.
		if (g == 0) begin : g_src
			assign v_in    = in_valid;
			assign den_in  = den;
			assign side_in = side;
		end else begin : g_src
			assign v_in    = g_stage[g-1].v_s;
			assign den_in  = g_stage[g-1].den_s;
			assign side_in = g_stage[g-1].side_s;
		end

		assign dsh = m3i_pkg::WW'(den_in) << K;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s <= 1'b0;
			else if (en)
				v_s <= v_in;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s  <= den_in;
				side_s <= side_in;
			end
		end

		for (l = 0; l < m3i_pkg::NL; l++) begin : g_lane
			logic [m3i_pkg::WW-1:0] rem_in;
			logic [m3i_pkg::QW-1:0] quo_in;
			logic [m3i_pkg::WW-1:0] rem_s;
			logic [m3i_pkg::QW-1:0] quo_s;
			logic [m3i_pkg::WW:0]   trial;

			if (g == 0) begin : g_src
				assign rem_in = num[l];
				assign quo_in = '0;
			end else begin : g_src
				assign rem_in = g_stage[g-1].g_lane[l].rem_s;
				assign quo_in = g_stage[g-1].g_lane[l].quo_s;
			end

			assign trial = {1'b0, rem_in} - {1'b0, dsh};

			always_ff @(posedge clk) begin
				if (en) begin
					if (!trial[m3i_pkg::WW]) begin
						rem_s <= trial[m3i_pkg::WW-1:0];
						quo_s <= quo_in | (m3i_pkg::QW'(1) << K);
					end else begin
						rem_s <= rem_in;
						quo_s <= quo_in;
					end
				end
			end
		end
	end

	for (l = 0; l < m3i_pkg::NL; l++) begin : g_out
		assign quo[l] = g_stage[m3i_pkg::QW-1].g_lane[l].quo_s;
	end

	assign out_valid = g_stage[m3i_pkg::QW-1].v_s;
	assign side_out  = g_stage[m3i_pkg::QW-1].side_s;

endmodule

// ----- hw/rtl/matrix3x3_inverse.sv -----
// 3x3 matrix inverse by the adjugate, signed Q16.16, with determinant and singular flag.
// Depends on m3i_pkg and instantiates the quotient pipeline m3i_div.
//
// The block takes one matrix per clock cycle while the output is not stalled, and returns
// each result through a chain of stages: eight stages form the cross products, the determinant
// and the dividends, the nine-lane divider resolves one quotient bit per stage over 33
// stages, and a last stage applies the sign, saturates and holds the output. All stages move
// together; when the output transaction is not taken the whole pipeline holds, so
// in_ready follows out_ready whenever a result is waiting. Outputs are rounded to
// nearest with ties away from zero and saturate to the 32-bit range. A zero
// determinant gives singular high with all inverse elements and the determinant zero.
module matrix3x3_inverse (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] m00,
	input  logic signed [31:0] m01,
	input  logic signed [31:0] m02,
	input  logic signed [31:0] m10,
	input  logic signed [31:0] m11,
	input  logic signed [31:0] m12,
	input  logic signed [31:0] m20,
	input  logic signed [31:0] m21,
	input  logic signed [31:0] m22,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] inv00,
	output logic signed [31:0] inv01,
	output logic signed [31:0] inv02,
	output logic signed [31:0] inv10,
	output logic signed [31:0] inv11,
	output logic signed [31:0] inv12,
	output logic signed [31:0] inv20,
	output logic signed [31:0] inv21,
	output logic signed [31:0] inv22,
	output logic signed [31:0] determinant,
	output logic               singular
);

	localparam int EW = m3i_pkg::EW;
	localparam int NL = m3i_pkg::NL;
	localparam int F  = m3i_pkg::FRAC_BITS;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s42;
	logic signed [EW-1:0] m_in [NL];

	logic signed [m3i_pkg::PW-1:0]   pa_s1 [NL];
	logic signed [m3i_pkg::PW-1:0]   pb_s1 [NL];
	logic signed [EW-1:0]            mc_s1 [3];
	logic signed [m3i_pkg::RW-1:0]   r_s2 [NL];
	logic signed [EW-1:0]            mc_s2 [3];
	logic signed [m3i_pkg::RW-1:0]   rabs [NL];
	logic signed [m3i_pkg::RW-1:0]   pl_s3 [3];
	logic signed [m3i_pkg::RW-1:0]   ph_s3 [3];
	logic [m3i_pkg::RMAGW-1:0]       rmag_s3 [NL];
	logic [NL-1:0]                   rneg_s3;
	logic signed [m3i_pkg::DETW-1:0] prod_s4 [3];
	logic [m3i_pkg::RMAGW-1:0]       rmag_s4 [NL];
	logic [NL-1:0]                   rneg_s4;
	logic signed [m3i_pkg::DETW-1:0] det_s5;
	logic [m3i_pkg::RMAGW-1:0]       rmag_s5 [NL];
	logic [NL-1:0]                   rneg_s5;
	logic signed [m3i_pkg::DETW-1:0] dabs;
	logic [m3i_pkg::DMAGW-1:0]       dmag_s6;
	logic                            dneg_s6;
	logic                            sing_s6;
	logic [m3i_pkg::RMAGW-1:0]       rmag_s6 [NL];
	logic [NL-1:0]                   rneg_s6;
	logic [m3i_pkg::NUMW-1:0]        num_s7 [NL];
	logic [m3i_pkg::DENW-1:0]        den_s7;
	logic [m3i_pkg::DMAGW:0]         drs_s7;
	logic [NL-1:0]                   qneg_s7;
	logic                            dneg_s7;
	logic                            sing_s7;
	logic [m3i_pkg::WW-1:0]          num_s8 [NL];
	logic [m3i_pkg::DENW-1:0]        den_s8;
	m3i_pkg::m3i_side_t              side_s8;
	logic                            v_dv;
	logic [m3i_pkg::QW-1:0]          quo_dv [NL];
	m3i_pkg::m3i_side_t              side_dv;
	logic signed [EW-1:0]            inv_s42 [NL];
	logic signed [EW-1:0]            det_s42;
	logic                            sing_s42;

	// The whole pipeline advances unless a result waits at the output.
	assign en       = !v_s42 || out_ready;
	assign in_ready = en;

	assign m_in[0] = m00;
	assign m_in[1] = m01;
	assign m_in[2] = m02;
	assign m_in[3] = m10;
	assign m_in[4] = m11;
	assign m_in[5] = m12;
	assign m_in[6] = m20;
	assign m_in[7] = m21;
	assign m_in[8] = m22;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s42 <= 1'b0;
		end else if (en) begin
			v_s1  <= in_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s42 <= v_dv;
		end
	end

	// Magnitudes of the cross products and the determinant.
	always_comb begin
		for (int i = 0; i < NL; i++)
			rabs[i] = r_s2[i][m3i_pkg::RW-1] ? -r_s2[i] : r_s2[i];
		dabs = det_s5[m3i_pkg::DETW-1] ? -det_s5 : det_s5;
	end

	// Stages one to eight: products, cross products, determinant and dividends.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NL; i++) begin
				pa_s1[i] <= m_in[m3i_pkg::XA[i]] * m_in[m3i_pkg::XB[i]];
				pb_s1[i] <= m_in[m3i_pkg::XC[i]] * m_in[m3i_pkg::XD[i]];
			end
			mc_s1[0] <= m02;
			mc_s1[1] <= m12;
			mc_s1[2] <= m22;

			for (int i = 0; i < NL; i++)
				r_s2[i] <= m3i_pkg::RW'(pa_s1[i]) - m3i_pkg::RW'(pb_s1[i]);
			mc_s2 <= mc_s1;

			// The last three cross products times the third column, each split in two halves.
			for (int j = 0; j < 3; j++) begin
				pl_s3[j] <= $signed({1'b0, r_s2[6+j][EW-1:0]}) * mc_s2[j];
				ph_s3[j] <= $signed(r_s2[6+j][m3i_pkg::RW-1:EW]) * mc_s2[j];
			end
			for (int i = 0; i < NL; i++) begin
				rmag_s3[i] <= rabs[i][m3i_pkg::RMAGW-1:0];
				rneg_s3[i] <= r_s2[i][m3i_pkg::RW-1];
			end

			for (int j = 0; j < 3; j++)
				prod_s4[j] <= (m3i_pkg::DETW'(ph_s3[j]) <<< EW) + m3i_pkg::DETW'(pl_s3[j]);
			rmag_s4 <= rmag_s3;
			rneg_s4 <= rneg_s3;

			det_s5  <= prod_s4[0] + prod_s4[1] + prod_s4[2];
			rmag_s5 <= rmag_s4;
			rneg_s5 <= rneg_s4;

			dmag_s6 <= dabs[m3i_pkg::DMAGW-1:0];
			dneg_s6 <= det_s5[m3i_pkg::DETW-1];
			sing_s6 <= (det_s5 == '0);
			rmag_s6 <= rmag_s5;
			rneg_s6 <= rneg_s5;

			// Dividend is 2r*2^(2F) + |det| over 2|det|, which rounds half away.
			for (int i = 0; i < NL; i++) begin
				num_s7[i]  <= (m3i_pkg::NUMW'(rmag_s6[i]) << (2 * F + 1))
					+ m3i_pkg::NUMW'(dmag_s6);
				qneg_s7[i] <= rneg_s6[i] ^ dneg_s6;
			end
			den_s7  <= {dmag_s6, 1'b0};
			drs_s7  <= {1'b0, dmag_s6} + ((m3i_pkg::DMAGW+1)'(1) << (2 * F - 1));
			dneg_s7 <= dneg_s6;
			sing_s7 <= sing_s6;

			// Quotients of 2^33 or more are flagged here and saturate at the end.
			for (int i = 0; i < NL; i++) begin
				num_s8[i]       <= m3i_pkg::WW'(num_s7[i]);
				side_s8.ovf[i]  <= m3i_pkg::WW'(num_s7[i])
					>= (m3i_pkg::WW'(den_s7) << m3i_pkg::QW);
			end
			den_s8       <= den_s7;
			side_s8.qneg <= qneg_s7;
			side_s8.sing <= sing_s7;
			side_s8.det  <= m3i_pkg::m3i_sat(dneg_s7,
				|drs_s7[m3i_pkg::DMAGW:2*F+m3i_pkg::QW],
				drs_s7[2*F+m3i_pkg::QW-1:2*F]);
		end
	end

	// Quotient bits, one per stage.
	m3i_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s8),
		.num      (num_s8),
		.den      (den_s8),
		.side     (side_s8),
		.out_valid(v_dv),
		.quo      (quo_dv),
		.side_out (side_dv)
	);

	// Output stage: sign, saturation and the singular case.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NL; i++)
				inv_s42[i] <= side_dv.sing ? '0
					: m3i_pkg::m3i_sat(side_dv.qneg[i], side_dv.ovf[i], quo_dv[i]);
			det_s42  <= side_dv.det;
			sing_s42 <= side_dv.sing;
		end
	end

	assign out_valid   = v_s42;
	assign inv00       = inv_s42[0];
	assign inv01       = inv_s42[1];
	assign inv02       = inv_s42[2];
	assign inv10       = inv_s42[3];
	assign inv11       = inv_s42[4];
	assign inv12       = inv_s42[5];
	assign inv20       = inv_s42[6];
	assign inv21       = inv_s42[7];
	assign inv22       = inv_s42[8];
	assign determinant = det_s42;
	assign singular    = sing_s42;

	// A singular result carries zeros in inv00, inv11, inv22, inv01, inv12 and inv20.
	a_sing_zero_inv: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> (inv00 == 0) && (inv11 == 0) && (inv22 == 0)
			&& (inv01 == 0) && (inv12 == 0) && (inv20 == 0))
		else $error("singular result with nonzero inverse");

	// A singular result carries a zero determinant.
	a_sing_zero_det: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> determinant == 0)
		else $error("singular result with nonzero determinant");

	// A stalled output freezes the first stage as well.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> v_s1 == $past(v_s1))
		else $error("pipeline moved during an output stall");

endmodule
